FILE: hw/rtl/axis_vector_rotator_macros.svh
`ifndef AXIS_VECTOR_ROTATOR_MACROS_SVH
`define AXIS_VECTOR_ROTATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define AVR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define AVR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/avr_pkg.sv
`timescale 1ns / 1ps

package avr_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int DP_W = 64;
  localparam int GUARD_BITS = 61 - COORD_WIDTH;
  localparam int MAG_W = DP_W - 1;
  localparam int R_W = MAG_W - GUARD_BITS;
  localparam int RES_W = 34;
  localparam int ANG_W = 17;
  localparam int ANGLE_SHIFT = 16;
  localparam int DEF_CORDIC_STAGES = 16;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 17'sd16384;
  localparam logic signed [ANG_W-1:0] HALF_TURN = 17'sd32768;
  localparam logic signed [RES_W-1:0] RES_QUARTER = 34'sd1073741824;

  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;
    logic signed [COORD_WIDTH-1:0] z_in;
    logic signed [15:0]            turn_angle;
    logic [1:0]                    axis_code;
  } point_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_out;
    logic signed [COORD_WIDTH-1:0] y_out;
    logic signed [COORD_WIDTH-1:0] z_out;
  } rotated_t;

  typedef struct packed {
    logic signed [DP_W-1:0]  a;
    logic signed [DP_W-1:0]  b;
    logic signed [RES_W-1:0] res;
  } cordic_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] z;
    logic [1:0]             axis;
  } side_t;

endpackage

FILE: hw/rtl/axis_vector_rotator.sv
// Rotates a 3D point about the x, y or z axis with an unrolled CORDIC.
// Input channel: point (point_t), point_valid, point_stall. A transfer
// happens on a rising edge with point_valid high and point_stall low.
// Output channel: rotated (rotated_t), rotated_valid, rotated_stall, same
// transfer rule. The coordinate along the chosen axis passes through, the
// other two are rotated by turn_angle (32768 = pi); axis code 3 passes all
// three coordinates unchanged. Results saturate to the 24-bit range.
// Pipeline: one input stage, one stage per CORDIC cell, five
// gain/round/saturate stages and the output register.
// Throughput: one point per cycle; every stage of the chain takes a new
// point each cycle the pipeline advances.
// Stalls: the output register is backed by a one-entry skid register. The
// pipeline keeps advancing while the output waits; once the skid register
// fills, point_stall goes high and the whole chain holds until the output
// drains it.
// Reset (rst, synchronous): clears all valid bits; no result is pending
// after it and the block accepts a point in the next cycle.
`timescale 1ns / 1ps
`include "axis_vector_rotator_macros.svh"

module axis_vector_rotator #(
  parameter int CORDIC_STAGES = avr_pkg::DEF_CORDIC_STAGES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              point_valid,
  output logic              point_stall,
  input  avr_pkg::point_t   point,
  output logic              rotated_valid,
  input  logic              rotated_stall,
  output avr_pkg::rotated_t rotated
);

  localparam int CW = avr_pkg::COORD_WIDTH;
  localparam int EXT_W = avr_pkg::DP_W - CW - avr_pkg::GUARD_BITS;

  logic                         en;
  logic                         skid_v;
  avr_pkg::rotated_t            skid;

  logic [CORDIC_STAGES:0]       chain_v;
  avr_pkg::cordic_t             chain_d [CORDIC_STAGES+1];
  avr_pkg::side_t               chain_s [CORDIC_STAGES+1];

  logic [CW-1:0]                a_raw;
  logic [CW-1:0]                b_raw;
  logic signed [avr_pkg::ANG_W-1:0] ang_full;
  logic signed [avr_pkg::ANG_W-1:0] ang_red;
  logic                         flip;
  logic signed [avr_pkg::DP_W-1:0] a_ext;
  logic signed [avr_pkg::DP_W-1:0] b_ext;
  avr_pkg::cordic_t             pre_next;
  avr_pkg::side_t               side_next;

  logic                         tail_v;
  avr_pkg::rotated_t            tail;

  assign en = !skid_v;
  assign point_stall = skid_v;

  always_comb begin
    case (point.axis_code)
      avr_pkg::AXIS_X: begin
        a_raw = point.y_in;
        b_raw = point.z_in;
      end
      avr_pkg::AXIS_Y: begin
        a_raw = point.z_in;
        b_raw = point.x_in;
      end
      avr_pkg::AXIS_Z: begin
        a_raw = point.x_in;
        b_raw = point.y_in;
      end
      default: begin
        a_raw = point.x_in;
        b_raw = point.y_in;
      end
    endcase

    ang_full = {point.turn_angle[15], point.turn_angle};
    if (ang_full > avr_pkg::QUARTER_TURN) begin
      ang_red = ang_full - avr_pkg::HALF_TURN;
      flip    = 1'b1;
    end else if (ang_full < -avr_pkg::QUARTER_TURN) begin
      ang_red = ang_full + avr_pkg::HALF_TURN;
      flip    = 1'b1;
    end else begin
      ang_red = ang_full;
      flip    = 1'b0;
    end

    a_ext = {{EXT_W{a_raw[CW-1]}}, a_raw, {avr_pkg::GUARD_BITS{1'b0}}};
    b_ext = {{EXT_W{b_raw[CW-1]}}, b_raw, {avr_pkg::GUARD_BITS{1'b0}}};
    pre_next.a   = flip ? -a_ext : a_ext;
    pre_next.b   = flip ? -b_ext : b_ext;
    pre_next.res = {{(avr_pkg::RES_W-avr_pkg::ANG_W-avr_pkg::ANGLE_SHIFT){ang_red[avr_pkg::ANG_W-1]}},
                    ang_red, {avr_pkg::ANGLE_SHIFT{1'b0}}};

    side_next.x    = point.x_in;
    side_next.y    = point.y_in;
    side_next.z    = point.z_in;
    side_next.axis = point.axis_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_v[0] <= 1'b0;
    end else if (en) begin
      chain_v[0] <= point_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain_d[0] <= pre_next;
      chain_s[0] <= side_next;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    avr_cordic_cell #(
      .STAGE(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (chain_v[i]),
      .in_data  (chain_d[i]),
      .in_side  (chain_s[i]),
      .out_valid(chain_v[i+1]),
      .out_data (chain_d[i+1]),
      .out_side (chain_s[i+1])
    );
  end

  avr_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (chain_v[CORDIC_STAGES]),
    .in_a     (chain_d[CORDIC_STAGES].a),
    .in_b     (chain_d[CORDIC_STAGES].b),
    .in_side  (chain_s[CORDIC_STAGES]),
    .out_valid(tail_v),
    .out_data (tail)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rotated_valid <= 1'b0;
      skid_v        <= 1'b0;
    end else if (skid_v) begin
      if (rotated_valid && !rotated_stall) begin
        skid_v <= 1'b0;
      end
    end else if (tail_v) begin
      if (!rotated_valid || !rotated_stall) begin
        rotated_valid <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (!rotated_stall) begin
      rotated_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (rotated_valid && !rotated_stall) begin
        rotated <= skid;
      end
    end else if (tail_v) begin
      if (!rotated_valid || !rotated_stall) begin
        rotated <= tail;
      end else begin
        skid <= tail;
      end
    end
  end

  `AVR_ASSERT_IMP(a_skid_backs_output, skid_v, rotated_valid)
  `AVR_ASSERT_NXT(a_skid_holds, skid_v && rotated_stall, skid_v)
  `AVR_ASSERT_IMP(a_angle_reduced, chain_v[0],
                  (chain_d[0].res <= avr_pkg::RES_QUARTER) &&
                  (chain_d[0].res >= -avr_pkg::RES_QUARTER))

endmodule

FILE: hw/rtl/avr_cordic_cell.sv
`timescale 1ns / 1ps

module avr_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  avr_pkg::cordic_t in_data,
  input  avr_pkg::side_t   in_side,
  output logic             out_valid,
  output avr_pkg::cordic_t out_data,
  output avr_pkg::side_t   out_side
);

  logic signed [avr_pkg::DP_W-1:0]  sa;
  logic signed [avr_pkg::DP_W-1:0]  sb;
  logic signed [avr_pkg::RES_W-1:0] step_angle;
  avr_pkg::cordic_t                 nxt;

  always_comb begin
    sa = in_data.a >>> STAGE;
    sb = in_data.b >>> STAGE;
    step_angle = {{(avr_pkg::RES_W-32){1'b0}}, avr_pkg::ATAN_TABLE[STAGE]};
    if (!in_data.res[avr_pkg::RES_W-1]) begin
      nxt.a   = in_data.a - sb;
      nxt.b   = in_data.b + sa;
      nxt.res = in_data.res - step_angle;
    end else begin
      nxt.a   = in_data.a + sb;
      nxt.b   = in_data.b - sa;
      nxt.res = in_data.res + step_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
      out_side <= in_side;
    end
  end

endmodule

FILE: hw/rtl/avr_finish.sv
`timescale 1ns / 1ps

module avr_finish (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [avr_pkg::DP_W-1:0] in_a,
  input  logic signed [avr_pkg::DP_W-1:0] in_b,
  input  avr_pkg::side_t                  in_side,
  output logic                            out_valid,
  output avr_pkg::rotated_t               out_data
);

  localparam logic [avr_pkg::MAG_W-1:0] ROUND_HALF =
    avr_pkg::MAG_W'(1) << (avr_pkg::GUARD_BITS - 1);
  localparam logic [avr_pkg::R_W-1:0] SAT_NEG =
    avr_pkg::R_W'(1) << (avr_pkg::COORD_WIDTH - 1);
  localparam logic [avr_pkg::R_W-1:0] SAT_POS = SAT_NEG - avr_pkg::R_W'(1);

  function automatic logic [avr_pkg::MAG_W-1:0] magnitude(
    input logic signed [avr_pkg::DP_W-1:0] v
  );
    logic signed [avr_pkg::DP_W-1:0] nv;
    nv = -v;
    return v[avr_pkg::DP_W-1] ? nv[avr_pkg::MAG_W-1:0] : v[avr_pkg::MAG_W-1:0];
  endfunction

  function automatic logic [avr_pkg::COORD_WIDTH-1:0] saturate(
    input logic [avr_pkg::R_W-1:0] r,
    input logic                    neg
  );
    logic [avr_pkg::R_W-1:0] rs;
    logic [avr_pkg::R_W-1:0] sv;
    if (neg) begin
      rs = (r > SAT_NEG) ? SAT_NEG : r;
      sv = -rs;
    end else begin
      rs = (r > SAT_POS) ? SAT_POS : r;
      sv = rs;
    end
    return sv[avr_pkg::COORD_WIDTH-1:0];
  endfunction

  logic [3:0]                 v;
  avr_pkg::side_t             side_s [4];
  logic [1:0]                 neg_s  [4];
  logic [avr_pkg::MAG_W-1:0]  mag    [2];
  logic [avr_pkg::MAG_W-1:0]  ph     [2];
  logic [31:0]                plh    [2];
  logic [avr_pkg::MAG_W-1:0]  psum   [2];
  logic [avr_pkg::R_W-1:0]    rnd    [2];

  logic [avr_pkg::MAG_W-1:0]  ph_next  [2];
  logic [63:0]                pl_next  [2];
  logic [avr_pkg::MAG_W-1:0]  rsum     [2];
  logic [avr_pkg::COORD_WIDTH-1:0] sat_a;
  logic [avr_pkg::COORD_WIDTH-1:0] sat_b;
  avr_pkg::rotated_t          remap;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      ph_next[k] = avr_pkg::MAG_W'(mag[k][avr_pkg::MAG_W-1:32]) *
                   avr_pkg::MAG_W'(avr_pkg::GAIN_Q32);
      pl_next[k] = 64'(mag[k][31:0]) * 64'(avr_pkg::GAIN_Q32);
      rsum[k]    = psum[k] + ROUND_HALF;
    end
  end

  always_comb begin
    sat_a = saturate(rnd[0], neg_s[3][0]);
    sat_b = saturate(rnd[1], neg_s[3][1]);
    case (side_s[3].axis)
      avr_pkg::AXIS_X: begin
        remap.x_out = side_s[3].x;
        remap.y_out = sat_a;
        remap.z_out = sat_b;
      end
      avr_pkg::AXIS_Y: begin
        remap.x_out = sat_b;
        remap.y_out = side_s[3].y;
        remap.z_out = sat_a;
      end
      avr_pkg::AXIS_Z: begin
        remap.x_out = sat_a;
        remap.y_out = sat_b;
        remap.z_out = side_s[3].z;
      end
      default: begin
        remap.x_out = side_s[3].x;
        remap.y_out = side_s[3].y;
        remap.z_out = side_s[3].z;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[2:0], in_valid};
      out_valid <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag[0]    <= magnitude(in_a);
      mag[1]    <= magnitude(in_b);
      neg_s[0]  <= {in_b[avr_pkg::DP_W-1], in_a[avr_pkg::DP_W-1]};
      side_s[0] <= in_side;
      for (int k = 0; k < 2; k++) begin
        ph[k]   <= ph_next[k];
        plh[k]  <= pl_next[k][63:32];
        psum[k] <= ph[k] + avr_pkg::MAG_W'(plh[k]);
        rnd[k]  <= rsum[k][avr_pkg::MAG_W-1:avr_pkg::GUARD_BITS];
      end
      for (int s = 1; s < 4; s++) begin
        neg_s[s]  <= neg_s[s-1];
        side_s[s] <= side_s[s-1];
      end
      out_data <= remap;
    end
  end

endmodule
